/* rtl/vdt_pkg.sv */
// Shared types and constants of the vertex deduplication table.
`default_nettype none

package vdt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;

  localparam int OP_W        = 2;
  localparam int COORD_W     = 16;
  localparam int VERTEX_W    = 3 * COORD_W;
  localparam int INDEX_OUT_W = 8;
  localparam int COUNT_OUT_W = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried on the input channel
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  // Work kind decided by the front end
  typedef enum logic [1:0] {
    K_CLEAR,
    K_APPEND,
    K_MERGE,
    K_NOP
  } item_kind_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    item_kind_t            kind;
    logic [VERTEX_W-1:0]   vertex;  // {z, y, x}
    logic                  last;
  } work_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EXEC
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/vdt_in_if.sv */
// Input channel: one vertex item with its operation code.
`default_nettype none

interface vdt_in_if;
  logic                               valid;
  logic                               ready;
  logic [vdt_pkg::OP_W-1:0]           op;
  logic signed [vdt_pkg::COORD_W-1:0] x_coord;
  logic signed [vdt_pkg::COORD_W-1:0] y_coord;
  logic signed [vdt_pkg::COORD_W-1:0] z_coord;
  logic                               last_in_face;

  modport source (output valid, op, x_coord, y_coord, z_coord, last_in_face, input ready);
  modport sink   (input valid, op, x_coord, y_coord, z_coord, last_in_face, output ready);
endinterface

`default_nettype wire

/* rtl/vdt_out_if.sv */
// Result channel: table index and status of one processed item.
`default_nettype none

interface vdt_out_if;
  logic                                valid;
  logic                                ready;
  logic [vdt_pkg::INDEX_OUT_W-1:0]     vertex_index;
  logic                                was_new;
  logic                                table_full;
  logic                                face_end;
  logic [vdt_pkg::COUNT_OUT_W-1:0]     entry_count;

  modport source (output valid, vertex_index, was_new, table_full, face_end, entry_count,
                  input ready);
  modport sink   (input valid, vertex_index, was_new, table_full, face_end, entry_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/vdt_front.sv */
// Front end: takes input transfers, classifies the op and feeds the work queue.
`default_nettype none

module vdt_front (
  input  wire logic    clk,
  input  wire logic    rst,
  vdt_in_if.sink       item,
  output vdt_pkg::work_t push_item,
  output logic         push_valid,
  input  wire logic    push_ready
);

  logic           hold_valid;
  vdt_pkg::work_t hold;
  vdt_pkg::work_t classified;

  // Decode the op into a work kind and pack the vertex
  always_comb begin
    classified.vertex = {item.z_coord, item.y_coord, item.x_coord};
    classified.last   = item.last_in_face;
    case (item.op)
      vdt_pkg::OP_CLEAR:  classified.kind = vdt_pkg::K_CLEAR;
      vdt_pkg::OP_APPEND: classified.kind = vdt_pkg::K_APPEND;
      vdt_pkg::OP_MERGE:  classified.kind = vdt_pkg::K_MERGE;
      default:            classified.kind = vdt_pkg::K_NOP;
    endcase
  end

  // Take a new item whenever the holding register is empty or drains now
  assign item.ready = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold <= classified;
    end
  end

endmodule

`default_nettype wire

/* rtl/vdt_queue.sv */
// Short work queue between the front end and the table engine.
`default_nettype none

module vdt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire vdt_pkg::work_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output vdt_pkg::work_t      pop_item,
  input  wire logic           pop
);

  localparam logic [vdt_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    vdt_pkg::QUEUE_PTR_W'(vdt_pkg::QUEUE_DEPTH - 1);
  localparam logic [vdt_pkg::QUEUE_CNT_W-1:0] FULL_FILL =
    vdt_pkg::QUEUE_CNT_W'(vdt_pkg::QUEUE_DEPTH);

  vdt_pkg::work_t                     slots [vdt_pkg::QUEUE_DEPTH];
  logic [vdt_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [vdt_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [vdt_pkg::QUEUE_CNT_W-1:0]    fill;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (fill != FULL_FILL);
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/vdt_back.sv */
// Table engine: vertex memory, linear merge search and result register.
`default_nettype none

module vdt_back #(
  parameter int TABLE_DEPTH = vdt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire vdt_pkg::work_t q_item,
  output logic                q_pop,
  vdt_out_if.source           result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  // Vertex memory: one write or one read per cycle, registered read data
  logic [vdt_pkg::VERTEX_W-1:0] mem [TABLE_DEPTH];
  logic [vdt_pkg::VERTEX_W-1:0] rdata;
  logic                         rd_en;
  logic                         mem_we;

  vdt_pkg::back_state_t state, state_next;
  vdt_pkg::work_t       cur, cur_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     scan_ptr, scan_ptr_next;
  logic                 rd_valid, rd_valid_next;
  logic [CNT_W-1:0]     rd_idx, rd_idx_next;
  logic                 hit, hit_next;
  logic [CNT_W-1:0]     hit_idx, hit_idx_next;
  logic [CNT_W-1:0]     rd_idx_inc;
  logic                 match;
  logic                 scan_stop;
  logic                 can_emit;
  logic                 emit;

  // Result values formed in the execute step
  logic [CNT_W-1:0]     res_idx;
  logic                 res_new;
  logic                 res_full;
  logic [CNT_W+vdt_pkg::INDEX_OUT_W-1:0] idx_ext;
  logic [CNT_W+vdt_pkg::COUNT_OUT_W-1:0] cnt_ext;

  assign match      = (rdata == cur.vertex);
  assign rd_idx_inc = rd_idx + 1'b1;
  assign scan_stop  = rd_valid && (match || (rd_idx_inc == count));
  assign can_emit   = !result.valid || result.ready;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    count_next    = count;
    scan_ptr_next = scan_ptr;
    rd_valid_next = 1'b0;
    rd_idx_next   = rd_idx;
    hit_next      = hit;
    hit_idx_next  = hit_idx;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    emit          = 1'b0;
    res_idx       = '0;
    res_new       = 1'b0;
    res_full      = 1'b0;
    case (state)
      vdt_pkg::B_IDLE: begin
        // Pull the next item; only a merge into a non-empty table searches
        if (q_valid) begin
          q_pop         = 1'b1;
          cur_next      = q_item;
          hit_next      = 1'b0;
          scan_ptr_next = '0;
          if (q_item.kind == vdt_pkg::K_MERGE && count != '0) begin
            state_next = vdt_pkg::B_SCAN;
          end else begin
            state_next = vdt_pkg::B_EXEC;
          end
        end
      end
      vdt_pkg::B_SCAN: begin
        // Issue one read per cycle, compare the entry read the cycle before
        if (scan_stop) begin
          hit_next     = match;
          hit_idx_next = rd_idx;
          state_next   = vdt_pkg::B_EXEC;
        end else if (scan_ptr < count) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
          rd_idx_next   = scan_ptr;
          scan_ptr_next = scan_ptr + 1'b1;
        end
      end
      vdt_pkg::B_EXEC: begin
        // Apply the op and load the result register
        if (can_emit) begin
          emit       = 1'b1;
          state_next = vdt_pkg::B_IDLE;
          case (cur.kind)
            vdt_pkg::K_CLEAR: begin
              count_next = '0;
            end
            vdt_pkg::K_APPEND, vdt_pkg::K_MERGE: begin
              if (hit) begin
                res_idx = hit_idx;
              end else if (count == FULL_COUNT) begin
                res_full = 1'b1;
              end else begin
                mem_we     = 1'b1;
                res_idx    = count;
                res_new    = 1'b1;
                count_next = count + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = vdt_pkg::B_IDLE;
      end
    endcase
  end

  assign idx_ext = {{vdt_pkg::INDEX_OUT_W{1'b0}}, res_idx};
  assign cnt_ext = {{vdt_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vdt_pkg::B_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_ptr <= scan_ptr_next;
    rd_idx   <= rd_idx_next;
    hit      <= hit_next;
    hit_idx  <= hit_idx_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= cur.vertex;
    end
    if (rd_en) begin
      rdata <= mem[scan_ptr[IDX_W-1:0]];
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.vertex_index <= idx_ext[vdt_pkg::INDEX_OUT_W-1:0];
      result.was_new      <= res_new;
      result.table_full   <= res_full;
      result.face_end     <= cur.last;
      result.entry_count  <= cnt_ext[vdt_pkg::COUNT_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/vertex_dedup_table.sv */
// Top level of the vertex deduplication table.
// Usage:
//   item   : input channel (valid/ready) with op, x/y/z coordinates and the
//            face-end marker. op clear empties the table, append stores the
//            vertex at the next free entry, merge returns the first equal
//            entry or stores the vertex when none matches.
//   result : one transfer per item with the table index, new/full flags,
//            the echoed face-end marker and the entry count after the item.
// A clear, append or unused op passes the input register, the queue and the
//   engine's idle and execute states before its result is registered; a merge
//   into a non-empty table also scans stored entries up to the first match.
// The engine pops a new item only once the current one is done; the search
//   reads the vertex memory through its single port, one entry per cycle.
// A two-entry queue sits between the front end and the table engine, so
//   items keep arriving during a search until the queue and input register
//   are full. A stalled result holds in the output register and the engine
//   waits with the next finished item; the inputs back up behind it.
// Reset empties the table (entry count zero) and drops queued items; vertex
//   memory contents are not cleared and need no clearing pass.
`default_nettype none

module vertex_dedup_table #(
  parameter int TABLE_DEPTH = vdt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vdt_in_if.sink     item,
  vdt_out_if.source  result
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W+vdt_pkg::COUNT_OUT_W-1:0] FULL_EXT =
    (CNT_W + vdt_pkg::COUNT_OUT_W)'(TABLE_DEPTH);

  vdt_pkg::work_t push_item;
  logic           push_valid;
  logic           push_ready;
  vdt_pkg::work_t pop_item;
  logic           pop_valid;
  logic           pop;

  vdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  vdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  vdt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop),
    .result  (result)
  );

`ifndef SYNTHESIS
  // A refused store only happens with the table at capacity
  a_full_at_depth: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.table_full |->
      result.entry_count == FULL_EXT[vdt_pkg::COUNT_OUT_W-1:0])
    else $error("table_full reported below capacity");

  // A refused store reports neither a new entry nor an index
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.table_full |->
      !result.was_new && result.vertex_index == '0)
    else $error("table_full result carries index or new flag");

  // A newly stored vertex always leaves a non-empty table
  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.was_new |-> result.entry_count != '0 && !result.table_full)
    else $error("new entry with empty table or full flag");
`endif

endmodule

`default_nettype wire
